// ===== rtl/fcca_pkg.sv =====
`timescale 1ns / 1ps

package fcca_pkg;

   // field widths of the stream beats
   localparam int OP_W      = 2;
   localparam int CLUSTER_W = 9;
   localparam int COUNT_W   = 10;
   localparam int STATUS_W  = 2;
   localparam int LINK_W    = 32;

   // operation codes
   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
   localparam logic [OP_W-1:0] OP_FOLLOW = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

   // link table markers
   localparam logic [LINK_W-1:0] EMPTY_MARK = 32'h0000_0000;
   localparam logic [LINK_W-1:0] END_MARK   = 32'h0FFF_FFFF;
   localparam logic [LINK_W-1:0] RES0_MARK  = 32'h0FFF_FFF0;

   // result of one operation
   typedef struct packed {
      logic                 chain_end;
      logic [STATUS_W-1:0]  status;
      logic [CLUSTER_W-1:0] cluster;
   } rsp_type;

   // classification of a link value by the shared compare unit
   typedef struct packed {
      logic is_unused;
      logic is_end;
      logic below_map;
      logic from_first;
   } link_info_type;

endpackage

// ===== rtl/fat_cluster_chain_allocator_top.sv =====
`timescale 1ns / 1ps
// Follow reads one table entry; free walks the chain one link at a time and allocate
// scans the table first-fit from FIRST_FREE, linking each cluster taken after the first.
// One operation at a time: the next request is taken in the cycle its result beat is
// first offered, so each operation holds the block until its result is handed on.
// Reset starts a clearing pass over all MAP_ENTRIES entries that loads the table's
// initial marks; req_tready stays low until it is done.

module fat_cluster_chain_allocator_top #(
   parameter int MAP_ENTRIES = 512,
   parameter int FIRST_FREE  = 3
) (
   input  logic        clock,
   input  logic        reset,
   // request beat
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // start_cluster[8:0], alloc_count[18:9], zero fill
   input  logic [1:0]  req_tuser,   // op[1:0]
   // result beat
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // cluster[8:0], status[10:9], chain_end[11], zero fill
);

   import fcca_pkg::*;

   localparam int IDX_W = $clog2(MAP_ENTRIES);

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [LINK_W-1:0]  wr_data;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [LINK_W-1:0]  rd_data;
   logic               res_valid;
   logic               res_free;
   rsp_type            res;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;

   fcca_ram #(
      .WIDTH (LINK_W),
      .DEPTH (MAP_ENTRIES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fcca_ctrl #(
      .MAP_ENTRIES (MAP_ENTRIES),
      .FIRST_FREE  (FIRST_FREE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tuser[OP_W-1:0]),
      .req_start (req_tdata[CLUSTER_W-1:0]),
      .req_count (req_tdata[CLUSTER_W+COUNT_W-1:CLUSTER_W]),
      .res_valid (res_valid),
      .res_free  (res_free),
      .res       (res),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // output register: frees the sequencer while a result waits
   assign res_free = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (res_valid && res_free) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_ff.chain_end, out_ff.status, out_ff.cluster};

endmodule

// ===== rtl/fcca_ram.sv =====
`timescale 1ns / 1ps

module fcca_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fcca_link_unit.sv =====
`timescale 1ns / 1ps

module fcca_link_unit #(
   parameter int MAP_ENTRIES = 512,
   parameter int FIRST_FREE  = 3
) (
   input  logic [fcca_pkg::LINK_W-1:0] link_val,
   output fcca_pkg::link_info_type     info
);

   import fcca_pkg::*;

   // marker and range compares shared by the sequencer's request check and its memory reads
   always_comb begin
      info.is_unused  = (link_val == EMPTY_MARK);
      info.is_end     = (link_val == END_MARK);
      info.below_map  = (link_val <  LINK_W'(MAP_ENTRIES));
      info.from_first = (link_val >= LINK_W'(FIRST_FREE));
   end

endmodule

// ===== rtl/fcca_ctrl.sv =====
`timescale 1ns / 1ps

module fcca_ctrl #(
   parameter int MAP_ENTRIES = 512,
   parameter int FIRST_FREE  = 3
) (
   input  logic                             clock,
   input  logic                             reset,
   // request side
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [fcca_pkg::OP_W-1:0]        req_op,
   input  logic [fcca_pkg::CLUSTER_W-1:0]   req_start,
   input  logic [fcca_pkg::COUNT_W-1:0]     req_count,
   // result side
   output logic                             res_valid,
   input  logic                             res_free,
   output fcca_pkg::rsp_type                res,
   // link memory
   output logic                             wr_en,
   output logic [$clog2(MAP_ENTRIES)-1:0]   wr_addr,
   output logic [fcca_pkg::LINK_W-1:0]      wr_data,
   output logic                             rd_en,
   output logic [$clog2(MAP_ENTRIES)-1:0]   rd_addr,
   input  logic [fcca_pkg::LINK_W-1:0]      rd_data
);

   import fcca_pkg::*;

   localparam int IDX_W = $clog2(MAP_ENTRIES);
   localparam int PTR_W = IDX_W + 1;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_ALLOC  = 3'd2;
   localparam logic [2:0] S_LINK   = 3'd3;
   localparam logic [2:0] S_FREE   = 3'd4;
   localparam logic [2:0] S_FOLLOW = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [PTR_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   prev_ff, prev_in;
   logic [IDX_W-1:0]   first_ff, first_in;
   logic               have_ff, have_in;
   logic [COUNT_W-1:0] got_ff, got_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   rsp_type            res_ff, res_in;

   logic [LINK_W-1:0]  chk_val;
   link_info_type      info;
   logic [PTR_W-1:0]   idx_plus;
   logic [COUNT_W-1:0] got_plus;
   logic               scan_done;
   logic               link_done;
   logic [IDX_W-1:0]   first_now;
   logic [IDX_W-1:0]   idx_lo;

   // shared compare unit: the request's cluster while idle, memory data otherwise
   assign chk_val = (state_ff == S_IDLE) ? LINK_W'(req_start) : rd_data;

   fcca_link_unit #(
      .MAP_ENTRIES (MAP_ENTRIES),
      .FIRST_FREE  (FIRST_FREE)
   ) u_link_unit (
      .link_val (chk_val),
      .info     (info)
   );

   // scan helpers
   assign idx_lo    = idx_ff[IDX_W-1:0];
   assign idx_plus  = idx_ff + PTR_W'(1);
   assign got_plus  = got_ff + COUNT_W'(info.is_unused);
   assign scan_done = (idx_plus >= PTR_W'(MAP_ENTRIES)) || (got_plus >= count_ff);
   assign link_done = (idx_plus >= PTR_W'(MAP_ENTRIES)) || (got_ff >= count_ff);
   assign first_now = have_ff ? first_ff : idx_lo;

   // table contents after reset
   function automatic logic [LINK_W-1:0] init_mark(input logic [PTR_W-1:0] idx);
      logic [LINK_W-1:0] mark;
      if (idx == PTR_W'(0)) begin
         mark = RES0_MARK;
      end else if (idx == PTR_W'(1) || idx == PTR_W'(2)) begin
         mark = END_MARK;
      end else begin
         mark = EMPTY_MARK;
      end
      return mark;
   endfunction

   // sequencer
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      prev_in  = prev_ff;
      first_in = first_ff;
      have_in  = have_ff;
      got_in   = got_ff;
      count_in = count_ff;
      res_in   = res_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_lo;
      wr_data  = EMPTY_MARK;
      rd_en    = 1'b0;
      rd_addr  = idx_lo;

      unique case (state_ff)
         // clearing pass, one entry a cycle
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = init_mark(idx_ff);
            idx_in  = idx_plus;
            if (idx_ff == PTR_W'(MAP_ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end

         // take a request and start its operation
         S_IDLE: begin
            res_in = '{chain_end: 1'b0, status: ST_BAD, cluster: '0};
            if (req_valid) begin
               state_in = S_RESP;
               case (req_op)
                  OP_ALLOC: begin
                     if (req_count != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = IDX_W'(FIRST_FREE);
                        idx_in   = PTR_W'(FIRST_FREE);
                        got_in   = '0;
                        have_in  = 1'b0;
                        count_in = req_count;
                        state_in = S_ALLOC;
                     end
                  end
                  OP_FREE: begin
                     if (info.below_map && info.from_first) begin
                        rd_en    = 1'b1;
                        rd_addr  = chk_val[IDX_W-1:0];
                        idx_in   = {1'b0, chk_val[IDX_W-1:0]};
                        state_in = S_FREE;
                     end
                  end
                  OP_FOLLOW: begin
                     if (info.below_map) begin
                        rd_en    = 1'b1;
                        rd_addr  = chk_val[IDX_W-1:0];
                        state_in = S_FOLLOW;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // first-fit scan, one entry a cycle, pausing in S_LINK for each entry taken after the first
         S_ALLOC: begin
            if (info.is_unused) begin
               wr_en   = 1'b1;
               wr_data = END_MARK;
               got_in  = got_plus;
            end
            if (info.is_unused && have_ff) begin
               state_in = S_LINK;
            end else begin
               if (info.is_unused) begin
                  first_in = idx_lo;
                  prev_in  = idx_lo;
                  have_in  = 1'b1;
               end
               if (scan_done) begin
                  res_in.cluster   = (have_ff || info.is_unused) ?
                                     CLUSTER_W'(first_now) : '0;
                  res_in.status    = (got_plus == count_ff) ? ST_OK : ST_FULL;
                  res_in.chain_end = 1'b0;
                  state_in         = S_RESP;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_plus[IDX_W-1:0];
                  idx_in  = idx_plus;
               end
            end
         end

         // link the previous tail to the entry just taken
         S_LINK: begin
            wr_en   = 1'b1;
            wr_addr = prev_ff;
            wr_data = LINK_W'(idx_lo);
            prev_in = idx_lo;
            if (link_done) begin
               res_in.cluster   = CLUSTER_W'(first_ff);
               res_in.status    = (got_ff == count_ff) ? ST_OK : ST_FULL;
               res_in.chain_end = 1'b0;
               state_in         = S_RESP;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_plus[IDX_W-1:0];
               idx_in   = idx_plus;
               state_in = S_ALLOC;
            end
         end

         // chain walk, one link a cycle
         S_FREE: begin
            if (info.is_unused) begin
               state_in = S_RESP;
            end else begin
               wr_en   = 1'b1;
               wr_data = EMPTY_MARK;
               if (info.is_end) begin
                  res_in.status = ST_OK;
                  state_in      = S_RESP;
               end else if (!(info.below_map && info.from_first) ||
                            (rd_data[IDX_W-1:0] == idx_lo)) begin
                  // broken link, or an entry that links to itself
                  state_in = S_RESP;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = rd_data[IDX_W-1:0];
                  idx_in  = {1'b0, rd_data[IDX_W-1:0]};
               end
            end
         end

         S_FOLLOW: begin
            if (info.is_end) begin
               res_in = '{chain_end: 1'b1, status: ST_OK, cluster: '0};
            end else if (!info.is_unused && info.below_map && info.from_first) begin
               res_in = '{chain_end: 1'b0, status: ST_OK, cluster: rd_data[CLUSTER_W-1:0]};
            end
            state_in = S_RESP;
         end

         // hand the result to the output register
         S_RESP: begin
            if (res_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff  <= prev_in;
      first_ff <= first_in;
      have_ff  <= have_in;
      got_ff   <= got_in;
      count_ff <= count_in;
      res_ff   <= res_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_RESP);
   assign res       = res_ff;

endmodule
